>>> rtl/core/three_phase_gate_driver_protection_assert.svh
// Assertion macros for the gate driver checker.
`ifndef THREE_PHASE_GATE_DRIVER_PROTECTION_ASSERT_SVH
`define THREE_PHASE_GATE_DRIVER_PROTECTION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gate driver check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TPGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gate driver check failed");

`endif

>>> rtl/core/tpgd_pkg.sv
// Types and constants for the three-phase gate driver protection block.
package tpgd_pkg;

    localparam int LEG_COUNT = 3;
    localparam int CODE_BITS = 12;
    localparam int AGE_BITS  = 16;
    localparam int CNT_BITS  = 16;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // register indexes on the config port
    localparam logic [2:0] REG_ENABLE_READY = 3'd0;
    localparam logic [2:0] REG_UVLO_FALL    = 3'd1;
    localparam logic [2:0] REG_UVLO_HYST    = 3'd2;
    localparam logic [2:0] REG_WARN_TEMP    = 3'd3;
    localparam logic [2:0] REG_SHDN_TEMP    = 3'd4;
    localparam logic [2:0] REG_DEAD_TIME    = 3'd5;
    localparam logic [2:0] REG_OC_LIMIT     = 3'd6;
    localparam logic [2:0] REG_OC_MODE      = 3'd7;

    // overcurrent modes; codes at or above OC_LATCH latch the leg
    localparam logic [1:0] OC_OFF   = 2'd0;
    localparam logic [1:0] OC_BLOCK = 2'd1;
    localparam logic [1:0] OC_LATCH = 2'd2;

    typedef struct packed {
        logic                        enable_gate;
        logic [LEG_COUNT-1:0]        high_inputs;
        logic [LEG_COUNT-1:0]        low_inputs;
        logic signed [CODE_BITS-1:0] current_a;
        logic signed [CODE_BITS-1:0] current_b;
        logic signed [CODE_BITS-1:0] current_c;
        logic [11:0]                 supply_level;
        logic [11:0]                 die_temperature;
        logic                        warn_force;
    } tick_word_t;

    typedef struct packed {
        logic [LEG_COUNT-1:0] gate_high;
        logic [LEG_COUNT-1:0] gate_low;
        logic                 fault_n;
        logic                 warning_n;
        logic                 is_ready;
        logic [CNT_BITS-1:0]  oc_event_count;
    } status_word_t;

    // shared controls from the top level to every leg
    typedef struct packed {
        logic                 advance;
        logic                 enabled;
        logic [1:0]           oc_mode;
        logic [AGE_BITS-1:0]  dead_time;
        logic [CODE_BITS-1:0] oc_limit;
    } leg_ctrl_t;

endpackage

>>> rtl/core/tpgd_leg.sv
// One half-bridge leg: truth table, shoot-through guard, dead time, overcurrent.
module tpgd_leg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tpgd_pkg::leg_ctrl_t                ctrl,
    input  logic                               high_in,
    input  logic                               low_in,
    input  logic                               high_last,
    input  logic                               low_last,
    input  logic signed [tpgd_pkg::CODE_BITS-1:0] current,
    output logic                               high_next,
    output logic                               low_next,
    output logic                               tripped_next,
    output logic                               trip_event
);
    import tpgd_pkg::*;

    logic                 high_on_reg, low_on_reg;
    logic                 high_blk_reg, low_blk_reg, trip_reg;
    logic [AGE_BITS-1:0]  high_age_reg, low_age_reg;

    logic                 high_blk_next, low_blk_next;
    logic [AGE_BITS-1:0]  high_age_next, low_age_next;
    logic [AGE_BITS-1:0]  high_age_inc, low_age_inc;
    logic                 high_blk, low_blk;
    logic                 want_h, want_l;
    logic [CODE_BITS-1:0] mag;
    logic                 latch_mode, oc_hit;

    always_comb
    begin
        high_age_inc = (high_age_reg == AGE_MAX) ? high_age_reg : high_age_reg + 1'b1;
        low_age_inc  = (low_age_reg == AGE_MAX) ? low_age_reg : low_age_reg + 1'b1;

        // a fresh rising input releases a cycle-by-cycle block
        high_blk = high_blk_reg & ~(high_in & ~high_last);
        low_blk  = low_blk_reg & ~(low_in & ~low_last);

        want_h = ctrl.enabled & high_in & ~low_in & ~trip_reg & ~high_blk;
        want_l = ctrl.enabled & low_in & ~high_in & ~trip_reg & ~low_blk;

        // dead-time floor, then never turn on against a conducting complement
        if (want_h && !high_on_reg && !low_on_reg && low_age_inc < ctrl.dead_time)
        begin
            want_h = 1'b0;
        end
        if (want_h && low_on_reg)
        begin
            want_h = 1'b0;
        end
        if (want_l && !low_on_reg && !high_on_reg && high_age_inc < ctrl.dead_time)
        begin
            want_l = 1'b0;
        end
        if (want_l && high_on_reg)
        begin
            want_l = 1'b0;
        end

        // most negative code maps to its exact magnitude as unsigned
        mag = current[CODE_BITS-1] ? (~current + 1'b1) : current;

        latch_mode = (ctrl.oc_mode >= OC_LATCH);
        oc_hit     = (ctrl.oc_mode != OC_OFF) & ctrl.enabled & (want_h | want_l)
                     & (mag > ctrl.oc_limit);

        high_age_next = high_age_inc;
        low_age_next  = low_age_inc;
        if ((high_on_reg && !want_h) || (oc_hit && (latch_mode || want_h)))
        begin
            high_age_next = '0;
        end
        if ((low_on_reg && !want_l) || (oc_hit && (latch_mode || want_l)))
        begin
            low_age_next = '0;
        end

        high_blk_next = high_blk | (oc_hit & ~latch_mode & want_h);
        low_blk_next  = low_blk | (oc_hit & ~latch_mode & want_l);
        tripped_next  = trip_reg | (oc_hit & latch_mode);

        high_next  = want_h & ~oc_hit;
        low_next   = want_l & ~oc_hit;
        trip_event = oc_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_on_reg  <= 1'b0;
            low_on_reg   <= 1'b0;
            high_blk_reg <= 1'b0;
            low_blk_reg  <= 1'b0;
            trip_reg     <= 1'b0;
            high_age_reg <= AGE_MAX;
            low_age_reg  <= AGE_MAX;
        end
        else if (ctrl.advance)
        begin
            high_on_reg  <= high_next;
            low_on_reg   <= low_next;
            high_blk_reg <= high_blk_next;
            low_blk_reg  <= low_blk_next;
            trip_reg     <= tripped_next;
            high_age_reg <= high_age_next;
            low_age_reg  <= low_age_next;
        end
    end

endmodule

>>> rtl/core/three_phase_gate_driver_protection.sv
// Three-phase gate driver with enable settle, UVLO, thermal and overcurrent protection.
//
// Usage: each tick word carries the gate enable, six PWM inputs, three phase
// currents, the supply code and the die temperature. One status word comes
// back per tick: gate drives, fault_n, warning_n, is_ready and the saturating
// overcurrent count.
// Channels: tick_valid/tick_stall in, status_valid/status_stall out; a word
// moves on a clock edge with valid high and stall low. Config registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high, and writes are meant for idle periods only.
// Path: an accepted tick waits in the input register, then one pass of
// protection logic writes its status word into the status register.
// Throughput: one tick per cycle while the status channel is not stalled; all state updates in that single pass.
// Stall: while status_stall holds a pending word, the input register fills and
// tick_stall rises only once both registers are occupied.
// Reset: config returns to defaults, off-age counters saturate, all latches,
// blocks and counts clear, both registers empty.
module three_phase_gate_driver_protection #(
    parameter int WARN_PULSE_TICKS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tick_valid,
    output logic                    tick_stall,
    input  tpgd_pkg::tick_word_t    tick_word,
    output logic                    status_valid,
    input  logic                    status_stall,
    output tpgd_pkg::status_word_t  status_word,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data
);
    import tpgd_pkg::*;

    localparam int WARN_BITS = $clog2(WARN_PULSE_TICKS + 1);
    localparam logic [WARN_BITS-1:0] WARN_LOAD = WARN_BITS'(WARN_PULSE_TICKS);

    // configuration registers
    logic [15:0]          enable_ready_reg;
    logic [11:0]          uvlo_fall_reg, uvlo_hyst_reg, warn_temp_reg, shdn_temp_reg;
    logic [15:0]          dead_time_reg;
    logic [CODE_BITS-1:0] oc_limit_reg;
    logic [1:0]           oc_mode_reg;

    // pipeline registers
    logic         tick_vld_reg;
    tick_word_t   tick_reg;
    logic         status_vld_reg;
    status_word_t status_reg;
    logic         advance;

    // block-level state
    logic                 last_en_reg, ready_reg, uv_reg, shdn_reg;
    logic [AGE_BITS-1:0]  en_age_reg, en_age_next;
    logic                 ready_next, uv_next, shdn_next, enabled;
    logic [WARN_BITS-1:0] warn_reg, warn_next, warn_cur;
    logic [LEG_COUNT-1:0] last_high_reg, last_low_reg;
    logic [CNT_BITS-1:0]  trip_cnt_reg, trip_cnt_next;
    logic [CNT_BITS:0]    trip_sum;
    logic [1:0]           trip_total;
    status_word_t         status_next;

    // per-leg results
    leg_ctrl_t                    leg_ctrl;
    logic [LEG_COUNT-1:0]         gate_high_next, gate_low_next, tripped_next, trip_event;
    logic signed [CODE_BITS-1:0]  leg_current [LEG_COUNT];

    assign cfg_ready = 1'b1;

    // the pass runs when an item waits and the status register can take it
    assign advance    = tick_vld_reg & (~status_vld_reg | ~status_stall);
    assign tick_stall = tick_vld_reg & ~advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_ready_reg <= 16'd1000;
            uvlo_fall_reg    <= 12'd1000;
            uvlo_hyst_reg    <= 12'd100;
            warn_temp_reg    <= 12'd3000;
            shdn_temp_reg    <= 12'd3500;
            dead_time_reg    <= 16'd4;
            oc_limit_reg     <= CODE_BITS'(2048);
            oc_mode_reg      <= OC_BLOCK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE_READY: enable_ready_reg <= cfg_data;
                REG_UVLO_FALL:    uvlo_fall_reg    <= cfg_data[11:0];
                REG_UVLO_HYST:    uvlo_hyst_reg    <= cfg_data[11:0];
                REG_WARN_TEMP:    warn_temp_reg    <= cfg_data[11:0];
                REG_SHDN_TEMP:    shdn_temp_reg    <= cfg_data[11:0];
                REG_DEAD_TIME:    dead_time_reg    <= cfg_data;
                REG_OC_LIMIT:     oc_limit_reg     <= cfg_data[CODE_BITS-1:0];
                REG_OC_MODE:      oc_mode_reg      <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // enable settle, UVLO hysteresis, thermal latch, warning stretch
    always_comb
    begin
        if (!tick_reg.enable_gate || !last_en_reg)
        begin
            en_age_next = '0;
        end
        else
        begin
            en_age_next = (en_age_reg == AGE_MAX) ? en_age_reg : en_age_reg + 1'b1;
        end
        ready_next = tick_reg.enable_gate & (ready_reg | (en_age_next >= enable_ready_reg));

        if (tick_reg.supply_level < uvlo_fall_reg)
        begin
            uv_next = 1'b1;
        end
        else if ({1'b0, tick_reg.supply_level} > ({1'b0, uvlo_fall_reg} + {1'b0, uvlo_hyst_reg}))
        begin
            uv_next = 1'b0;
        end
        else
        begin
            uv_next = uv_reg;
        end

        // enable low clears the thermal latch; still hot sets it again
        shdn_next = (tick_reg.enable_gate & shdn_reg)
                    | (tick_reg.die_temperature >= shdn_temp_reg);

        enabled = tick_reg.enable_gate & ready_next & ~uv_next & ~shdn_next;

        leg_ctrl.advance   = advance;
        leg_ctrl.enabled   = enabled;
        leg_ctrl.oc_mode   = oc_mode_reg;
        leg_ctrl.dead_time = dead_time_reg;
        leg_ctrl.oc_limit  = oc_limit_reg;

        leg_current[0] = tick_reg.current_a;
        leg_current[1] = tick_reg.current_b;
        leg_current[2] = tick_reg.current_c;

        // a forced warning, any trip or a hot die reloads the warning stretch
        if (tick_reg.warn_force || (tick_reg.die_temperature >= warn_temp_reg) || (|trip_event))
        begin
            warn_cur = WARN_LOAD;
        end
        else
        begin
            warn_cur = warn_reg;
        end
        warn_next = (warn_cur != '0) ? warn_cur - 1'b1 : warn_cur;

        // up to one trip per leg in a tick
        trip_total    = {1'b0, trip_event[0]} + {1'b0, trip_event[1]} + {1'b0, trip_event[2]};
        trip_sum      = {1'b0, trip_cnt_reg} + (CNT_BITS + 1)'(trip_total);
        trip_cnt_next = trip_sum[CNT_BITS] ? CNT_MAX : trip_sum[CNT_BITS-1:0];

        status_next.gate_high      = gate_high_next;
        status_next.gate_low       = gate_low_next;
        status_next.fault_n        = ~(uv_next | shdn_next | (|tripped_next)) & ready_next;
        status_next.warning_n      = (warn_cur == '0);
        status_next.is_ready       = ready_next;
        status_next.oc_event_count = trip_cnt_next;
    end

    for (genvar k = 0; k < LEG_COUNT; k++)
    begin : g_leg
        tpgd_leg u_leg (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (leg_ctrl),
            .high_in      (tick_reg.high_inputs[k]),
            .low_in       (tick_reg.low_inputs[k]),
            .high_last    (last_high_reg[k]),
            .low_last     (last_low_reg[k]),
            .current      (leg_current[k]),
            .high_next    (gate_high_next[k]),
            .low_next     (gate_low_next[k]),
            .tripped_next (tripped_next[k]),
            .trip_event   (trip_event[k])
        );
    end

    // block state advances with each processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_en_reg   <= 1'b0;
            en_age_reg    <= '0;
            ready_reg     <= 1'b0;
            uv_reg        <= 1'b0;
            shdn_reg      <= 1'b0;
            warn_reg      <= '0;
            last_high_reg <= '0;
            last_low_reg  <= '0;
            trip_cnt_reg  <= '0;
        end
        else if (advance)
        begin
            last_en_reg   <= tick_reg.enable_gate;
            en_age_reg    <= en_age_next;
            ready_reg     <= ready_next;
            uv_reg        <= uv_next;
            shdn_reg      <= shdn_next;
            warn_reg      <= warn_next;
            last_high_reg <= tick_reg.high_inputs;
            last_low_reg  <= tick_reg.low_inputs;
            trip_cnt_reg  <= trip_cnt_next;
        end
    end

    // input and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg   <= 1'b0;
            status_vld_reg <= 1'b0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
            begin
                tick_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                tick_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                status_vld_reg <= 1'b1;
            end
            else if (!status_stall)
            begin
                status_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
        begin
            tick_reg <= tick_word;
        end
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign status_valid = status_vld_reg;
    assign status_word  = status_reg;

endmodule

>>> rtl/core/tpgd_checker.sv
// Port-level checker for the gate driver, bound to the top level.
`include "three_phase_gate_driver_protection_assert.svh"

module tpgd_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    status_valid,
    input logic                    status_stall,
    input tpgd_pkg::status_word_t  status_word
);
    import tpgd_pkg::*;

    logic any_drive;

    assign any_drive = |(status_word.gate_high | status_word.gate_low);

    // shoot-through guard: never both FETs of a leg on
    `TPGD_ASSERT_NOW(a_no_shoot_through, status_valid, (status_word.gate_high & status_word.gate_low) == '0)

    // before the settle period ends nothing drives and fault is reported
    `TPGD_ASSERT_NOW(a_idle_until_ready, status_valid && !status_word.is_ready, !any_drive && !status_word.fault_n)

    // a stalled status word holds
    `TPGD_ASSERT_NEXT(a_status_hold, status_valid && status_stall, status_valid && $stable(status_word))

endmodule

bind three_phase_gate_driver_protection tpgd_checker u_tpgd_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the three-phase gate driver protection block.
module tb_top;
    import tpgd_pkg::*;

    localparam int PERIOD     = 12;
    localparam int WARN_TICKS = 64;
    localparam int MAX_CYCLES = 200000;

    // Upper oc_mode code; the block treats it like OC_LATCH.
    localparam logic [1:0] OC_LATCH_HI = 2'd3;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         tick_valid   = 1'b0;
    logic         tick_stall;
    tick_word_t   tick_word    = '0;
    logic         status_valid;
    logic         status_stall = 1'b0;
    status_word_t status_word;
    logic         cfg_valid    = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index    = REG_ENABLE_READY;
    logic [15:0]  cfg_data     = '0;

    three_phase_gate_driver_protection #(
        .WARN_PULSE_TICKS(WARN_TICKS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .tick_word   (tick_word),
        .status_valid(status_valid),
        .status_stall(status_stall),
        .status_word (status_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus store, expected status words, bookkeeping
    // ------------------------------------------------------------------
    tick_word_t   pending_ticks[$];   // words waiting for the driver
    status_word_t status_due[$];      // predicted status, oldest first
    int           ticks_queued   = 0;
    int           ticks_accepted = 0;
    int           mismatches     = 0;
    logic         tick_taken     = 1'b0;  // tick word moved at last rising edge
    logic         cfg_hit        = 1'b0;  // config write landed at last rising edge

    // idle knobs, changed per phase
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int big_pct       = 15;   // share of phase currents drawn over the full code range

    // random tick generator state: enable level and PWM pattern persist
    logic                 gen_enable = 1'b0;
    logic [LEG_COUNT-1:0] gen_high   = '0;
    logic [LEG_COUNT-1:0] gen_low    = '0;

    // ------------------------------------------------------------------
    // Predictor: register copy (reset values) and block state
    // ------------------------------------------------------------------
    logic [15:0] set_ready_ticks = 16'd1000;
    logic [11:0] set_uv_fall     = 12'd1000;
    logic [11:0] set_uv_hyst     = 12'd100;
    logic [11:0] set_warn_temp   = 12'd3000;
    logic [11:0] set_shdn_temp   = 12'd3500;
    logic [15:0] set_dead_ticks  = 16'd4;
    logic [11:0] set_oc_limit    = 12'd2048;
    logic [1:0]  set_oc_mode     = OC_BLOCK;

    logic                 en_prev    = 1'b0;
    logic [AGE_BITS-1:0]  en_age     = '0;
    logic                 ready_q    = 1'b0;
    logic                 uv_q       = 1'b0;
    logic                 shdn_q     = 1'b0;
    int                   warn_left  = 0;
    logic [LEG_COUNT-1:0] pwm_h_prev = '0;
    logic [LEG_COUNT-1:0] pwm_l_prev = '0;
    logic [LEG_COUNT-1:0] h_block    = '0;
    logic [LEG_COUNT-1:0] l_block    = '0;
    logic [LEG_COUNT-1:0] tripped    = '0;
    logic [LEG_COUNT-1:0] h_drive    = '0;
    logic [LEG_COUNT-1:0] l_drive    = '0;
    logic [AGE_BITS-1:0]  h_off_age [LEG_COUNT] = '{default: AGE_MAX};
    logic [AGE_BITS-1:0]  l_off_age [LEG_COUNT] = '{default: AGE_MAX};
    logic [CNT_BITS-1:0]  trip_total = '0;

    function automatic logic [15:0] sat_up(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // One control tick: advance the state and return the status word it yields.
    function automatic status_word_t predict_status(tick_word_t w);
        status_word_t         s;
        logic                 run;
        logic                 in_h, in_l, on_h, on_l, want_h, want_l;
        logic [CODE_BITS-1:0] code;
        int                   mag;

        // off ages run every tick, saturating
        for (int k = 0; k < LEG_COUNT; k++)
        begin
            h_off_age[k] = sat_up(h_off_age[k]);
            l_off_age[k] = sat_up(l_off_age[k]);
        end

        // enable settle; dropping enable also releases the thermal latch
        if (!w.enable_gate)
        begin
            en_age  = '0;
            ready_q = 1'b0;
            shdn_q  = 1'b0;
        end
        else
        begin
            en_age = en_prev ? sat_up(en_age) : '0;
            if (en_age >= set_ready_ticks)
                ready_q = 1'b1;
        end
        en_prev = w.enable_gate;

        // UVLO with hysteresis; the clear level is not clipped to 12 bits
        if (w.supply_level < set_uv_fall)
            uv_q = 1'b1;
        else if (int'(w.supply_level) > int'(set_uv_fall) + int'(set_uv_hyst))
            uv_q = 1'b0;

        if (w.die_temperature >= set_shdn_temp)
            shdn_q = 1'b1;
        if (w.warn_force || w.die_temperature >= set_warn_temp)
            warn_left = WARN_TICKS;

        run = w.enable_gate && ready_q && !uv_q && !shdn_q;

        for (int k = 0; k < LEG_COUNT; k++)
        begin
            in_h = w.high_inputs[k];
            in_l = w.low_inputs[k];
            on_h = h_drive[k];
            on_l = l_drive[k];

            // a rising PWM input releases a cycle-by-cycle block
            if (in_h && !pwm_h_prev[k])
                h_block[k] = 1'b0;
            if (in_l && !pwm_l_prev[k])
                l_block[k] = 1'b0;

            // 6-PWM truth table: exactly one input high drives
            want_h = run && in_h && !in_l;
            want_l = run && in_l && !in_h;
            if (tripped[k])
            begin
                want_h = 1'b0;
                want_l = 1'b0;
            end
            if (h_block[k])
                want_h = 1'b0;
            if (l_block[k])
                want_l = 1'b0;

            // dead-time floor from an idle leg, and never switch straight across
            if (want_h && !on_h && !on_l && l_off_age[k] < set_dead_ticks)
                want_h = 1'b0;
            if (want_h && on_l)
                want_h = 1'b0;
            if (want_l && !on_l && !on_h && h_off_age[k] < set_dead_ticks)
                want_l = 1'b0;
            if (want_l && on_h)
                want_l = 1'b0;

            if (on_h && !want_h)
                h_off_age[k] = '0;
            if (on_l && !want_l)
                l_off_age[k] = '0;
            on_h = want_h;
            on_l = want_l;

            // overcurrent on a conducting leg; most negative code has magnitude 2048
            code = (k == 0) ? w.current_a : (k == 1) ? w.current_b : w.current_c;
            mag  = code[CODE_BITS-1] ? (1 << CODE_BITS) - int'(code) : int'(code);
            if (set_oc_mode != OC_OFF && run && (on_h || on_l) && mag > int'(set_oc_limit))
            begin
                trip_total = sat_up(trip_total);
                warn_left  = WARN_TICKS;
                if (set_oc_mode >= OC_LATCH)
                begin
                    tripped[k]   = 1'b1;
                    on_h         = 1'b0;
                    on_l         = 1'b0;
                    h_off_age[k] = '0;
                    l_off_age[k] = '0;
                end
                else
                begin
                    if (on_h)
                    begin
                        h_block[k]   = 1'b1;
                        on_h         = 1'b0;
                        h_off_age[k] = '0;
                    end
                    if (on_l)
                    begin
                        l_block[k]   = 1'b1;
                        on_l         = 1'b0;
                        l_off_age[k] = '0;
                    end
                end
            end

            h_drive[k] = on_h;
            l_drive[k] = on_l;
        end
        pwm_h_prev = w.high_inputs;
        pwm_l_prev = w.low_inputs;

        s.gate_high      = h_drive;
        s.gate_low       = l_drive;
        s.fault_n        = !(uv_q || shdn_q || tripped != '0) && ready_q;
        s.warning_n      = (warn_left == 0);
        s.is_ready       = ready_q;
        s.oc_event_count = trip_total;

        // warning stretch counts down after the word is formed
        if (warn_left != 0)
            warn_left--;
        return s;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, name, exp_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Tick acceptance
    // feeds the predictor; status acceptance is checked against the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        status_word_t want;
        if (rst_n)
        begin
            tick_taken = tick_valid && !tick_stall;
            cfg_hit    = cfg_valid && cfg_ready;
            if (tick_taken)
            begin
                status_due.push_back(predict_status(tick_word));
                ticks_accepted++;
            end
            if (status_valid && !status_stall)
            begin
                if (status_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: status word with none expected: %0h",
                                 $time, status_word);
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("gate_high", want.gate_high, status_word.gate_high);
                    check_field("gate_low", want.gate_low, status_word.gate_low);
                    check_field("fault_n", want.fault_n, status_word.fault_n);
                    check_field("warning_n", want.warning_n, status_word.warning_n);
                    check_field("is_ready", want.is_ready, status_word.is_ready);
                    check_field("oc_event_count", want.oc_event_count,
                                status_word.oc_event_count);
                end
            end
        end
        else
        begin
            tick_taken = 1'b0;
            cfg_hit    = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Driver: inputs move at the falling edge. A held word stays put until
    // it is taken; each falling edge gives tick_valid one assignment at most.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic go;
        if (rst_n && (!tick_valid || tick_taken))
        begin
            go = (pending_ticks.size() != 0) && ($urandom_range(1, 100) > send_idle_pct);
            if (go)
                tick_word <= pending_ticks.pop_front();
            tick_valid <= go;
        end
    end

    // receiver back-pressure on the status channel
    always @(negedge clk)
    begin
        if (rst_n)
            status_stall <= ($urandom_range(1, 100) <= stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_tick(bit en, int hi, int lo, int ia, int ib, int ic,
                              int sup, int heat, bit warn);
        tick_word_t t;
        t.enable_gate     = en;
        t.high_inputs     = hi[LEG_COUNT-1:0];
        t.low_inputs      = lo[LEG_COUNT-1:0];
        t.current_a       = ia[CODE_BITS-1:0];
        t.current_b       = ib[CODE_BITS-1:0];
        t.current_c       = ic[CODE_BITS-1:0];
        t.supply_level    = sup[11:0];
        t.die_temperature = heat[11:0];
        t.warn_force      = warn;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Mostly well-formed drive: enable held in long runs, supply healthy,
    // die cool, complementary PWM per leg, modest currents. The rest is
    // full-range noise so every field bit toggles.
    function automatic tick_word_t make_tick();
        tick_word_t t;
        int         cur [LEG_COUNT];
        int         lo_sup, hi_heat, r;

        if (gen_enable)
        begin
            if ($urandom_range(1, 100) <= 2)
                gen_enable = 1'b0;
        end
        else if ($urandom_range(1, 100) <= 35)
            gen_enable = 1'b1;

        if ($urandom_range(1, 100) <= 5)
        begin
            gen_high = LEG_COUNT'($urandom_range(0, 7));
            gen_low  = LEG_COUNT'($urandom_range(0, 7));
        end
        else if ($urandom_range(1, 100) <= 30)
        begin
            for (int k = 0; k < LEG_COUNT; k++)
            begin
                r = $urandom_range(0, 19);
                gen_high[k] = (r <= 8) || (r == 19);
                gen_low[k]  = (r >= 9 && r <= 16) || (r == 19);
            end
        end

        for (int k = 0; k < LEG_COUNT; k++)
            cur[k] = ($urandom_range(1, 100) <= big_pct) ? int'($urandom_range(0, 4095))
                                                         : int'($urandom_range(0, 800)) - 400;

        lo_sup = int'(set_uv_fall) + int'(set_uv_hyst) + 1;
        if (lo_sup > 4095)
            lo_sup = 4095;
        hi_heat = (set_warn_temp < set_shdn_temp) ? int'(set_warn_temp) : int'(set_shdn_temp);
        hi_heat = (hi_heat > 0) ? hi_heat - 1 : 0;

        t.enable_gate     = gen_enable;
        t.high_inputs     = gen_high;
        t.low_inputs      = gen_low;
        t.current_a       = cur[0][CODE_BITS-1:0];
        t.current_b       = cur[1][CODE_BITS-1:0];
        t.current_c       = cur[2][CODE_BITS-1:0];
        t.supply_level    = ($urandom_range(1, 100) <= 8) ? 12'($urandom_range(0, 4095))
                                                          : 12'($urandom_range(lo_sup, 4095));
        t.die_temperature = ($urandom_range(1, 100) <= 6) ? 12'($urandom_range(0, 4095))
                                                          : 12'($urandom_range(0, hi_heat));
        t.warn_force      = ($urandom_range(1, 100) <= 3);
        return t;
    endfunction

    // Wait until every queued word has been taken and answered, then let
    // the two-stage pipe drain before touching registers.
    task automatic settle();
        while (ticks_accepted != ticks_queued || status_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write; the predictor copy changes at the edge that took it.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_hit);
        case (idx)
            REG_ENABLE_READY: set_ready_ticks = val;
            REG_UVLO_FALL:    set_uv_fall     = val[11:0];
            REG_UVLO_HYST:    set_uv_hyst     = val[11:0];
            REG_WARN_TEMP:    set_warn_temp   = val[11:0];
            REG_SHDN_TEMP:    set_shdn_temp   = val[11:0];
            REG_DEAD_TIME:    set_dead_ticks  = val;
            REG_OC_LIMIT:     set_oc_limit    = val[11:0];
            REG_OC_MODE:      set_oc_mode     = val[1:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(int ready, int fall, int hyst, int warn, int shdn,
                               int dead, int limit, logic [1:0] mode);
        write_reg(REG_ENABLE_READY, ready[15:0]);
        write_reg(REG_UVLO_FALL, fall[15:0]);
        write_reg(REG_UVLO_HYST, hyst[15:0]);
        write_reg(REG_WARN_TEMP, warn[15:0]);
        write_reg(REG_SHDN_TEMP, shdn[15:0]);
        write_reg(REG_DEAD_TIME, dead[15:0]);
        write_reg(REG_OC_LIMIT, limit[15:0]);
        write_reg(REG_OC_MODE, {14'd0, mode});
    endtask

    task automatic run_phase(int n, int snd, int rcv, int big);
        send_idle_pct = snd;
        stall_pct     = rcv;
        big_pct       = big;
        for (int i = 0; i < n; i++)
        begin
            pending_ticks.push_back(make_tick());
            ticks_queued++;
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: long settle keeps the gates off; hot die latches
        queue_tick(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_tick(1, 7, 0, 0, 0, 0, 4095, 0, 0);
        queue_tick(1, 7, 0, 0, 0, 0, 4095, 0, 0);
        queue_tick(1, 0, 7, 2047, -2048, 0, 4095, 4095, 0);
        settle();

        // short settle, dead time of two, cycle-by-cycle blocking
        load_config(1, 1000, 100, 3000, 3500, 2, 1000, OC_BLOCK);
        queue_tick(0, 0, 0, 0, 0, 0, 4095, 0, 0);            // enable low clears shutdown
        queue_tick(1, 0, 0, 0, 0, 0, 4095, 0, 0);            // enable rise, age restarts
        queue_tick(1, 7, 0, 0, 0, 0, 4095, 0, 0);            // ready, highs drive
        queue_tick(1, 7, 0, 100, -100, 5, 4095, 0, 0);
        queue_tick(1, 0, 7, 0, 0, 0, 4095, 0, 0);            // highs release first
        queue_tick(1, 0, 7, 0, 0, 0, 4095, 0, 0);            // still inside dead time
        queue_tick(1, 0, 7, 0, 0, 0, 4095, 0, 0);            // lows drive
        queue_tick(1, 7, 7, 0, 0, 0, 4095, 0, 0);            // both inputs high: leg off
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 0, 0);
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 0, 0);
        queue_tick(1, 1, 6, 1001, -1000, -2048, 4095, 0, 0); // just over, at limit, min code
        queue_tick(1, 1, 6, 2047, 0, 0, 4095, 0, 0);         // blocked until input rises
        queue_tick(1, 0, 6, 0, 0, 0, 4095, 0, 0);
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 0, 0);            // rise releases the block
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 0, 1);            // forced warning
        queue_tick(1, 1, 6, 0, 0, 0, 999, 0, 0);             // below falling level
        queue_tick(1, 1, 6, 0, 0, 0, 1100, 0, 0);            // inside hysteresis band
        queue_tick(1, 1, 6, 0, 0, 0, 1101, 0, 0);            // clears
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 3000, 0);         // warning threshold
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 3500, 0);         // shutdown threshold
        queue_tick(0, 1, 6, 0, 0, 0, 4095, 0, 0);
        queue_tick(1, 1, 6, 0, 0, 0, 4095, 0, 0);
        settle();

        // overcurrent off, no idling on either side
        load_config(4, 1200, 50, 2900, 3400, 2, 900, OC_OFF);
        run_phase(90, 0, 0, 15);

        // zero thresholds, zero dead time, every nonzero current on a driving leg trips
        load_config(0, 0, 0, 4095, 4095, 0, 0, OC_BLOCK);
        run_phase(90, 86, 0, 15);

        // top-of-range registers: never ready, always hot, and undervolt never clears once set
        load_config(65535, 4095, 4095, 0, 0, 65535, 0, OC_BLOCK);
        run_phase(40, 0, 86, 15);

        load_config(2, 800, 200, 3200, 3600, 3, 1200, OC_BLOCK);
        run_phase(80, 8, 8, 15);

        // latching from here on; tripped legs stay off for the rest of the run
        load_config(1, 700, 300, 3100, 3700, 1, 1500, OC_LATCH_HI);
        run_phase(80, 0, 86, 3);

        load_config(3, 900, 100, 3000, 3500, 5, 2048, OC_LATCH);
        run_phase(80, 86, 0, 20);

        if (mismatches == 0 && status_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #(PERIOD * MAX_CYCLES);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
